### hw/rtl/wgm_pkg.sv
// Package for the glob wildcard matcher: opcodes, glob bytes and word types.
// No dependencies; imported by every module of the block.
package wgm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } wgm_op_e;

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    wgm_op_e    opcode;
    logic [7:0] byte_value;
  } wgm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } wgm_out_t;

  // classified word as held in the queue
  typedef struct packed {
    wgm_op_e    op;
    logic [7:0] value;
    logic       is_star;
    logic       is_qmark;
  } wgm_item_t;

endpackage

### hw/rtl/wgm_front.sv
// Front end of the glob matcher: classifies input words and queues them.
// Depends on wgm_pkg.
module wgm_front import wgm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  wgm_in_t   in_data_i,
  output logic      head_valid_o,
  input  logic      head_ready_i,
  output wgm_item_t head_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  wgm_item_t            q_mem [QUEUE_DEPTH];
  wgm_item_t            item;
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 push, pop;

  always_comb begin
    item.op       = in_data_i.opcode;
    item.value    = in_data_i.byte_value;
    item.is_star  = (in_data_i.byte_value == STAR_BYTE);
    item.is_qmark = (in_data_i.byte_value == QMARK_BYTE);
  end

  assign in_ready_o   = (cnt_q != CntW'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = q_mem[rd_ptr_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = head_valid_o & head_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

endmodule

### hw/rtl/wgm_back.sv
// Back end of the glob matcher: pattern cells, active-position vector,
// star closure by parallel prefix, and the result register. Depends on wgm_pkg.
module wgm_back import wgm_pkg::*; #(
  parameter int unsigned PatternLen = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  output logic      head_ready_o,
  input  wgm_item_t head_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output wgm_out_t  out_data_o
);

  localparam int unsigned LenW = $clog2(PatternLen + 1);
  localparam int unsigned IdxW = $clog2(PatternLen);
  localparam int unsigned Lv   = $clog2(PatternLen + 1);

  logic [7:0]            pat_q [PatternLen];
  logic [PatternLen-1:0] qm_q;
  logic [PatternLen-1:0] star_q, star_d;
  logic [PatternLen-1:0] used_q, used_d;
  logic [LenW-1:0]       len_q, len_d;
  logic                  ovf_q, ovf_d;
  logic [PatternLen:0]   act_q, act_d;
  logic [PatternLen:0]   stepv, base;
  logic [Lv:0][PatternLen:0] g_s, p_s;
  logic                  out_valid_q, out_valid_d;
  wgm_out_t              out_q, out_d;
  logic                  fire, full, wr_en, out_free;
  logic [IdxW-1:0]       wr_idx;

  assign full         = used_q[PatternLen-1];
  assign out_free     = ~out_valid_q | out_ready_i;
  assign head_ready_o = (head_i.op != OP_END) | out_free;
  assign fire         = head_valid_i & head_ready_o;
  assign wr_en        = fire & (head_i.op == OP_APPEND) & ~full;
  assign wr_idx       = len_q[IdxW-1:0];
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  // one text byte against every live cell
  always_comb begin
    stepv = '0;
    for (int i = 0; i < PatternLen; i++) begin
      if (act_q[i] & used_q[i]) begin
        if (star_q[i]) begin
          stepv[i] = 1'b1;
        end else if (qm_q[i] | (pat_q[i] == head_i.value)) begin
          stepv[i+1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    used_d  = used_q;
    star_d  = star_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    base    = '0;
    base[0] = 1'b1;
    case (head_i.op)
      OP_CLEAR: begin
        used_d = '0;
        len_d  = '0;
        ovf_d  = 1'b0;
      end
      OP_APPEND: begin
        if (!full) begin
          used_d[wr_idx] = 1'b1;
          star_d[wr_idx] = head_i.is_star;
          len_d          = len_q + LenW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      OP_TEXT: begin
        base = stepv;
      end
      default: begin
      end
    endcase
  end

  // segmented OR scan: a run of stars carries activity forward
  always_comb begin
    g_s[0]    = base;
    p_s[0]    = '0;
    for (int j = 1; j <= PatternLen; j++) begin
      p_s[0][j] = used_d[j-1] & star_d[j-1];
    end
    for (int k = 0; k < Lv; k++) begin
      for (int j = 0; j <= PatternLen; j++) begin
        if (j >= (1 << k)) begin
          g_s[k+1][j] = g_s[k][j] | (p_s[k][j] & g_s[k][j-(1<<k)]);
          p_s[k+1][j] = p_s[k][j] & p_s[k][j-(1<<k)];
        end else begin
          g_s[k+1][j] = g_s[k][j];
          p_s[k+1][j] = p_s[k][j];
        end
      end
    end
    act_d = g_s[Lv];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire && (head_i.op == OP_END)) begin
      out_valid_d            = 1'b1;
      out_d.matched          = ~ovf_q & act_q[len_q];
      out_d.pattern_overflow = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      act_q       <= (PatternLen + 1)'(1);
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        used_q <= used_d;
        len_q  <= len_d;
        ovf_q  <= ovf_d;
        act_q  <= act_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (fire) begin
      star_q <= star_d;
    end
    if (wr_en) begin
      pat_q[wr_idx] <= head_i.value;
      qm_q[wr_idx]  <= head_i.is_qmark;
    end
  end

  a_len_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(len_q))
    else $error("pattern length and filled cells disagree");

  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q & ~{used_q, 1'b1}) == '0)
    else $error("active position beyond pattern end");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flagged with free pattern cells");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (head_i.op == OP_END)) |=> out_valid_q)
    else $error("end of text gave no result word");

endmodule

### hw/rtl/wildcard_glob_matcher.sv
// Glob wildcard matcher ('?' any byte, '*' any run of bytes).
// Input word: opcode and byte; output word: match and overflow bits.
// A front end classifies and queues input words (two-word queue); the back
// end holds the pattern cells and the active-position vector.
// Each word is executed as the back end accepts it, so one word per cycle
// is sustained unless an end-of-text word waits on a busy result register;
// its result shows on the output register in the cycle after the back end
// accepts it. Clear, append and text-byte words give no result.
// The back end advances all pattern positions in parallel and closes over
// runs of '*' with a log-depth prefix scan, which sets the cycle time.
// Reset empties the pattern, clears the overflow flag and restarts matching.
// The pattern store itself is not cleared. While a result waits for the
// receiver, text and pattern words keep flowing; a further end-of-text word
// waits in the queue, and the input stalls only once the queue is full.
// Depends on wgm_pkg, wgm_front and wgm_back.
module wildcard_glob_matcher import wgm_pkg::*; #(
  parameter int unsigned PATTERN_LEN = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wgm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output wgm_out_t out_data_o
);

  logic      head_valid, head_ready;
  wgm_item_t head;

  wgm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_ready_i (head_ready),
    .head_o       (head)
  );

  wgm_back #(
    .PatternLen (PATTERN_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .head_i       (head),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

### tb/wildcard_glob_matcher_tb.sv
// Testbench for wildcard_glob_matcher: directed and random words with random idling on
// both channels, results checked against a predictor held in a scoreboard class.
// Depends on wgm_pkg and the wildcard_glob_matcher RTL.
`timescale 1ns / 100ps

module wildcard_glob_matcher_tb;
  import wgm_pkg::*;

  localparam int unsigned PATTERN_LEN = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  wgm_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  wgm_out_t out_data_o;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 51;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;

  logic [7:0] pat_copy [$];
  logic [7:0] text_q [$];

  class glob_match_tracker;
    logic [7:0]           pat_bytes [PATTERN_LEN];
    int unsigned          pat_len;
    logic [PATTERN_LEN:0] live;
    bit                   over;
    wgm_out_t             pending_results [$];
    int unsigned          failures;

    function new();
      pat_len  = 0;
      over     = 1'b0;
      failures = 0;
      restart();
    endfunction

    function void spread_stars();
      for (int i = 0; i < pat_len; i++) begin
        if (live[i] && pat_bytes[i] == STAR_BYTE) live[i+1] = 1'b1;
      end
    endfunction

    function void restart();
      live    = '0;
      live[0] = 1'b1;
      spread_stars();
    endfunction

    function void take_word(wgm_in_t w);
      logic [PATTERN_LEN:0] nxt;
      wgm_out_t             r;
      case (w.opcode)
        OP_CLEAR: begin
          pat_len = 0;
          over    = 1'b0;
          restart();
        end
        OP_APPEND: begin
          if (pat_len < PATTERN_LEN) begin
            pat_bytes[pat_len] = w.byte_value;
            pat_len++;
          end else begin
            over = 1'b1;
          end
          restart();
        end
        OP_TEXT: begin
          nxt = '0;
          for (int i = 0; i < pat_len; i++) begin
            if (live[i]) begin
              if (pat_bytes[i] == STAR_BYTE) nxt[i] = 1'b1;
              else if (pat_bytes[i] == QMARK_BYTE || pat_bytes[i] == w.byte_value)
                nxt[i+1] = 1'b1;
            end
          end
          live = nxt;
          spread_stars();
        end
        default: begin
          r.matched          = !over && live[pat_len];
          r.pattern_overflow = over;
          pending_results = {pending_results, r};
          restart();
        end
      endcase
    endfunction

    function void check_result(wgm_out_t got);
      wgm_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %b", $time, got);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.matched !== want.matched) begin
          $display("%0t: matched expected %b actual %b", $time, want.matched, got.matched);
          failures++;
        end
        if (got.pattern_overflow !== want.pattern_overflow) begin
          $display("%0t: pattern_overflow expected %b actual %b", $time,
                   want.pattern_overflow, got.pattern_overflow);
          failures++;
        end
      end
    endfunction
  endclass

  glob_match_tracker tracker = new();

  wildcard_glob_matcher #(.PATTERN_LEN(PATTERN_LEN)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wildcard_glob_matcher verification failed");
      $finish;
    end
  end

  // valid is only lowered during idle cycles, never in the step it is raised
  task automatic send_word(input wgm_op_e op, input logic [7:0] b);
    wgm_in_t w;
    w.opcode     = op;
    w.byte_value = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_word(w);
    words_sent++;
  endtask

  function automatic logic [7:0] text_byte();
    case ($urandom_range(7))
      5:       return STAR_BYTE;
      6:       return QMARK_BYTE;
      7:       return 8'($urandom);
      default: return 8'h61 + 8'($urandom_range(2));
    endcase
  endfunction

  function automatic logic [7:0] pattern_byte();
    case ($urandom_range(9))
      0, 1:    return STAR_BYTE;
      2:       return QMARK_BYTE;
      8, 9:    return 8'($urandom);
      default: return 8'h61 + 8'($urandom_range(2));
    endcase
  endfunction

  // text mostly shaped to fit the pattern, sometimes random or with one byte spoilt
  function automatic void make_text();
    text_q.delete();
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(6)) text_q = {text_q, text_byte()};
    end else begin
      foreach (pat_copy[i]) begin
        if (pat_copy[i] == STAR_BYTE) repeat ($urandom_range(3)) text_q = {text_q, text_byte()};
        else if (pat_copy[i] == QMARK_BYTE) text_q = {text_q, 8'($urandom)};
        else text_q = {text_q, pat_copy[i]};
      end
      if (text_q.size() != 0 && $urandom_range(99) < 15)
        text_q[$urandom_range(text_q.size() - 1)] = text_byte();
    end
  endfunction

  task automatic append_byte(input logic [7:0] b);
    send_word(OP_APPEND, b);
    if (pat_copy.size() < PATTERN_LEN) pat_copy = {pat_copy, b};
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned plen;
    wgm_op_e     op;
    logic [7:0]  b;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        op = wgm_op_e'($urandom_range(3));
        b  = 8'($urandom);
        if (op == OP_APPEND) begin
          append_byte(b);
        end else begin
          send_word(op, b);
          if (op == OP_CLEAR) pat_copy.delete();
        end
      end else begin
        if ($urandom_range(9) != 0) begin
          send_word(OP_CLEAR, 8'($urandom));
          pat_copy.delete();
        end
        plen = ($urandom_range(99) < 6) ? $urandom_range(36, 30) : $urandom_range(8);
        repeat (plen) append_byte(pattern_byte());
        repeat ($urandom_range(4, 1)) begin
          make_text();
          foreach (text_q[i]) begin
            if ($urandom_range(99) < 3) append_byte(pattern_byte());
            send_word(OP_TEXT, text_q[i]);
          end
          send_word(OP_END, 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern: empty text matches, any text does not
    send_word(OP_END, 8'hFF);
    send_word(OP_TEXT, 8'h00);
    send_word(OP_END, 8'h00);
    // stars only, then star in pattern against star in text
    send_word(OP_APPEND, STAR_BYTE);
    send_word(OP_APPEND, STAR_BYTE);
    send_word(OP_END, 8'h00);
    send_word(OP_TEXT, STAR_BYTE);
    send_word(OP_TEXT, 8'hFF);
    send_word(OP_END, 8'h00);
    // literal, query and NUL
    send_word(OP_CLEAR, 8'hFF);
    send_word(OP_APPEND, 8'h61);
    send_word(OP_APPEND, QMARK_BYTE);
    send_word(OP_APPEND, 8'h00);
    send_word(OP_TEXT, 8'h61);
    send_word(OP_TEXT, 8'hFF);
    send_word(OP_TEXT, 8'h00);
    send_word(OP_END, 8'h00);
    // pattern grows mid-word: partial text forgotten
    send_word(OP_TEXT, 8'h61);
    send_word(OP_APPEND, STAR_BYTE);
    send_word(OP_TEXT, 8'h61);
    send_word(OP_TEXT, 8'h62);
    send_word(OP_TEXT, 8'h00);
    send_word(OP_TEXT, 8'h7A);
    send_word(OP_END, 8'h00);
    send_word(OP_CLEAR, 8'h00);
    send_word(OP_END, 8'h00);

    for (int i = 0; i < 4; i++) pat_copy = {pat_copy, 8'h00};
    pat_copy.delete();

    run_random(260);
    send_idle_pct = 51;
    recv_idle_pct = 35;
    run_random(260);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(260);

    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.failures == 0) begin
      $display("wildcard_glob_matcher verification clean");
    end else begin
      $display("wildcard_glob_matcher verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_front.sv
hw/rtl/wgm_back.sv
hw/rtl/wildcard_glob_matcher.sv
tb/wildcard_glob_matcher_tb.sv
